[hdl/ps2mpt_pkg.sv]
// Package: payload types, register indexes and constants of the PS/2 mouse packet tracker.
package ps2mpt_pkg;

    localparam int COORD_BITS  = 12;
    localparam int SCREEN_BITS = 13;
    localparam int SUM_W       = SCREEN_BITS + 2;
    localparam int COORD_MAX   = (1 << COORD_BITS) - 1;

    localparam int CURSOR_W_DEFAULT = 13;
    localparam int CURSOR_H_DEFAULT = 20;

    localparam logic [SCREEN_BITS-1:0] RESET_WIDTH  = SCREEN_BITS'(640);
    localparam logic [SCREEN_BITS-1:0] RESET_HEIGHT = SCREEN_BITS'(480);
    localparam logic [COORD_BITS-1:0]  RESET_COL    = COORD_BITS'(640 / 2);
    localparam logic [COORD_BITS-1:0]  RESET_ROW    = COORD_BITS'(480 / 2);

    localparam int CFG_INDEX_BITS = 2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_WHEEL_MODE    = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SCREEN_WIDTH  = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SCREEN_HEIGHT = 2'd2;

    localparam int HDR_LEFT   = 0;
    localparam int HDR_RIGHT  = 1;
    localparam int HDR_MIDDLE = 2;
    localparam int HDR_SYNC   = 3;
    localparam int HDR_X_SIGN = 4;
    localparam int HDR_Y_SIGN = 5;

    typedef struct packed {
        logic       aux_flag;
        logic [7:0] data_byte;
    } mouse_byte_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] pos_x;
        logic [COORD_BITS-1:0] pos_y;
        logic                  btn_left;
        logic                  btn_right;
        logic                  btn_middle;
        logic                  press_left;
        logic                  press_right;
        logic signed [3:0]     wheel_step;
    } report_t;

    typedef struct packed {
        logic [CFG_INDEX_BITS-1:0] reg_index;
        logic [SCREEN_BITS-1:0]    reg_data;
    } cfg_write_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] hdr;
        logic [7:0] dx;
        logic [7:0] dy;
        logic [3:0] scroll;
    } packet_t;

endpackage

[hdl/ps2mpt_chan_if.sv]
// Interface: valid/ready channel carrying one payload per transfer.
interface ps2mpt_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[hdl/ps2mpt_assembler.sv]
// Assembler: input byte register and packet byte gathering.
module ps2mpt_assembler (
    input  logic                       clk,
    input  logic                       rst_n,
    ps2mpt_chan_if.sink                mouse,
    input  logic                       wheel_mode,
    input  logic                       advance,
    output ps2mpt_pkg::packet_t        pkt
);

    logic       stage_valid_reg;
    logic       aux_reg;
    logic [7:0] data_reg;
    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    logic [7:0] hdr_reg;
    logic [7:0] dx_reg;
    logic [7:0] dy_reg;
    logic       complete;
    logic       consume;

    assign complete = (3'(idx_reg) + 3'd1) >= (wheel_mode ? 3'd4 : 3'd3);

    always_comb
    begin
        pkt.valid  = stage_valid_reg && aux_reg && complete && hdr_reg[ps2mpt_pkg::HDR_SYNC];
        pkt.hdr    = hdr_reg;
        pkt.dx     = dx_reg;
        pkt.dy     = (idx_reg == 2'd2) ? data_reg : dy_reg;
        pkt.scroll = (idx_reg == 2'd3 && wheel_mode) ? data_reg[3:0] : 4'd0;
    end

    assign consume     = stage_valid_reg && (advance || !pkt.valid);
    assign mouse.ready = !stage_valid_reg || consume;

    always_comb
    begin
        idx_next = idx_reg;
        if (consume && aux_reg)
        begin
            idx_next = complete ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            idx_reg         <= 2'd0;
            hdr_reg         <= 8'd0;
            dx_reg          <= 8'd0;
            dy_reg          <= 8'd0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (mouse.ready)
            begin
                stage_valid_reg <= mouse.valid;
            end
            if (consume && aux_reg && !complete)
            begin
                case (idx_reg)
                    2'd0:    hdr_reg <= data_reg;
                    2'd1:    dx_reg  <= data_reg;
                    default: dy_reg  <= data_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mouse.valid && mouse.ready)
        begin
            aux_reg  <= mouse.payload.aux_flag;
            data_reg <= mouse.payload.data_byte;
        end
    end

    a_stall_only_on_packet: assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid_reg && !consume |-> pkt.valid)
        else $error("byte stage stalled without a finished packet");

    a_ignored_byte_keeps_index: assert property (@(posedge clk) disable iff (!rst_n)
        consume && !aux_reg |=> $stable(idx_reg))
        else $error("non-aux byte moved the byte index");

endmodule

[hdl/ps2mpt_tracker.sv]
// Tracker: configuration registers, pointer position, button history and result register.
module ps2mpt_tracker #(
    parameter int CURSOR_W = ps2mpt_pkg::CURSOR_W_DEFAULT,
    parameter int CURSOR_H = ps2mpt_pkg::CURSOR_H_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ps2mpt_pkg::packet_t pkt,
    ps2mpt_chan_if.sink         cfg,
    ps2mpt_chan_if.source       report,
    output logic                wheel_mode,
    output logic                advance
);

    localparam int W  = ps2mpt_pkg::SUM_W;
    localparam int CB = ps2mpt_pkg::COORD_BITS;

    logic                              wheel_reg;
    logic [ps2mpt_pkg::SCREEN_BITS-1:0] width_reg;
    logic [ps2mpt_pkg::SCREEN_BITS-1:0] height_reg;
    logic [CB-1:0]                     col_reg;
    logic [CB-1:0]                     row_reg;
    logic [CB-1:0]                     col_next;
    logic [CB-1:0]                     row_next;
    logic                              last_left_reg;
    logic                              last_right_reg;
    logic                              res_valid_reg;
    ps2mpt_pkg::report_t               res_reg;
    logic [CB-1:0]                     hi_x;
    logic [CB-1:0]                     hi_y;
    logic signed [8:0]                 rel_x;
    logic signed [8:0]                 rel_y;
    logic signed [W-1:0]               col_sum;
    logic signed [W-1:0]               row_sum;
    logic                              load;
    logic                              cfg_write;

    function automatic logic [CB-1:0] sat_coord(input logic signed [W-1:0] v);
        logic [CB-1:0] r;
        if (v[W-1])
        begin
            r = '0;
        end
        else if (v > W'(ps2mpt_pkg::COORD_MAX))
        begin
            r = CB'(ps2mpt_pkg::COORD_MAX);
        end
        else
        begin
            r = v[CB-1:0];
        end
        return r;
    endfunction

    function automatic logic [CB-1:0] clamp_to(input logic signed [W-1:0] v,
                                               input logic [CB-1:0] hi);
        logic [CB-1:0] r;
        if (v[W-1])
        begin
            r = '0;
        end
        else if (v[W-2:0] > (W-1)'(hi))
        begin
            r = hi;
        end
        else
        begin
            r = v[CB-1:0];
        end
        return r;
    endfunction

    assign hi_x = sat_coord(W'(width_reg) - W'(CURSOR_W));
    assign hi_y = sat_coord(W'(height_reg) - W'(CURSOR_H));

    assign rel_x   = {pkt.hdr[ps2mpt_pkg::HDR_X_SIGN], pkt.dx};
    assign rel_y   = {pkt.hdr[ps2mpt_pkg::HDR_Y_SIGN], pkt.dy};
    assign col_sum = W'(col_reg) + W'(rel_x);
    assign row_sum = W'(row_reg) - W'(rel_y);
    assign col_next = clamp_to(col_sum, hi_x);
    assign row_next = clamp_to(row_sum, hi_y);

    assign advance    = !res_valid_reg || report.ready;
    assign load       = pkt.valid && advance;
    assign cfg.ready  = 1'b1;
    assign cfg_write  = cfg.valid;
    assign wheel_mode = wheel_reg;

    assign report.valid   = res_valid_reg;
    assign report.payload = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wheel_reg      <= 1'b0;
            width_reg      <= ps2mpt_pkg::RESET_WIDTH;
            height_reg     <= ps2mpt_pkg::RESET_HEIGHT;
            col_reg        <= ps2mpt_pkg::RESET_COL;
            row_reg        <= ps2mpt_pkg::RESET_ROW;
            last_left_reg  <= 1'b0;
            last_right_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg.payload.reg_index)
                    ps2mpt_pkg::CFG_WHEEL_MODE:
                    begin
                        wheel_reg <= cfg.payload.reg_data[0];
                    end
                    ps2mpt_pkg::CFG_SCREEN_WIDTH:
                    begin
                        width_reg <= cfg.payload.reg_data;
                        col_reg   <= sat_coord(W'(cfg.payload.reg_data >> 1));
                    end
                    ps2mpt_pkg::CFG_SCREEN_HEIGHT:
                    begin
                        height_reg <= cfg.payload.reg_data;
                        row_reg    <= sat_coord(W'(cfg.payload.reg_data >> 1));
                    end
                    default:
                    begin
                    end
                endcase
            end
            else if (load)
            begin
                col_reg        <= col_next;
                row_reg        <= row_next;
                last_left_reg  <= pkt.hdr[ps2mpt_pkg::HDR_LEFT];
                last_right_reg <= pkt.hdr[ps2mpt_pkg::HDR_RIGHT];
            end
            if (advance)
            begin
                res_valid_reg <= pkt.valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg.pos_x       <= col_next;
            res_reg.pos_y       <= row_next;
            res_reg.btn_left    <= pkt.hdr[ps2mpt_pkg::HDR_LEFT];
            res_reg.btn_right   <= pkt.hdr[ps2mpt_pkg::HDR_RIGHT];
            res_reg.btn_middle  <= pkt.hdr[ps2mpt_pkg::HDR_MIDDLE];
            res_reg.press_left  <= pkt.hdr[ps2mpt_pkg::HDR_LEFT] && !last_left_reg;
            res_reg.press_right <= pkt.hdr[ps2mpt_pkg::HDR_RIGHT] && !last_right_reg;
            res_reg.wheel_step  <= pkt.scroll;
        end
    end

    a_pos_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> (res_reg.pos_x <= hi_x) && (res_reg.pos_y <= hi_y))
        else $error("reported position outside the screen bounds");

    a_load_sets_result: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> res_valid_reg && (res_reg.pos_x == col_reg) && (res_reg.pos_y == row_reg))
        else $error("result register out of step with pointer state");

endmodule

[hdl/ps2_mouse_packet_tracker_core.sv]
// Top level: PS/2 mouse packet tracker core.
//
//   channel  dir  payload                      transfer when
//   mouse    in   aux_flag, data_byte          mouse.valid & mouse.ready
//   report   out  position, buttons, scroll    report.valid & report.ready
//   cfg      in   reg_index, reg_data          cfg.valid & cfg.ready (ready held high)
//
// One byte per cycle unless the byte stage stalls.
// The path is the byte register, the clamped add and the result register.
// Bytes keep flowing into the byte register while a result waits; the byte stage stalls
// only when it holds a packet-completing byte and the result register is still full.
// Reset restores 640x480, standard packets and a centered pointer; no clearing pass.
module ps2_mouse_packet_tracker_core #(
    parameter int CURSOR_W = ps2mpt_pkg::CURSOR_W_DEFAULT,
    parameter int CURSOR_H = ps2mpt_pkg::CURSOR_H_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    ps2mpt_chan_if.sink   mouse,
    ps2mpt_chan_if.source report,
    ps2mpt_chan_if.sink   cfg
);

    ps2mpt_pkg::packet_t pkt;
    logic                wheel_mode;
    logic                advance;

    ps2mpt_assembler u_assembler (
        .clk        (clk),
        .rst_n      (rst_n),
        .mouse      (mouse),
        .wheel_mode (wheel_mode),
        .advance    (advance),
        .pkt        (pkt)
    );

    ps2mpt_tracker #(
        .CURSOR_W (CURSOR_W),
        .CURSOR_H (CURSOR_H)
    ) u_tracker (
        .clk        (clk),
        .rst_n      (rst_n),
        .pkt        (pkt),
        .cfg        (cfg),
        .report     (report),
        .wheel_mode (wheel_mode),
        .advance    (advance)
    );

endmodule
